@@ hdl/dll_pkg.sv @@
package dll_pkg;

  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int LinkW = IdxW + 1;
  localparam logic [LinkW-1:0] Nil = LinkW'(Capacity);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT_AFT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_DELETE     = 3'd5,
    OP_SORT       = 3'd6,
    OP_READ       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOKEY = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_WAIT,
    S_LOOK,
    S_LINK,
    S_UNLINK,
    S_SORT_A,
    S_SORT_B,
    S_SORT_C,
    S_EMIT,
    S_DONE
  } state_t;

  // One write port to the node store.
  typedef struct packed {
    logic              val_we;
    logic              nxt_we;
    logic              prv_we;
    logic [IdxW-1:0]   addr;
    logic [31:0]       val;
    logic [LinkW-1:0]  nxt;
    logic [LinkW-1:0]  prv;
  } node_wr_t;

  typedef struct packed {
    logic [31:0]      val;
    logic [LinkW-1:0] nxt;
    logic [LinkW-1:0] prv;
  } node_rd_t;

endpackage

@@ hdl/dll_node_mem.sv @@
module dll_node_mem (
  input  logic                 clk,
  input  dll_pkg::node_wr_t    wr,
  input  logic [dll_pkg::IdxW-1:0] rd_addr,
  output dll_pkg::node_rd_t    rd
);
  import dll_pkg::*;

  logic [31:0]      val_mem [Capacity];
  logic [LinkW-1:0] nxt_mem [Capacity];
  logic [LinkW-1:0] prv_mem [Capacity];

  always_ff @(posedge clk) begin
    if (wr.val_we) val_mem[wr.addr] <= wr.val;
    if (wr.nxt_we) nxt_mem[wr.addr] <= wr.nxt;
    if (wr.prv_we) prv_mem[wr.addr] <= wr.prv;
    rd.val <= val_mem[rd_addr];
    rd.nxt <= nxt_mem[rd_addr];
    rd.prv <= prv_mem[rd_addr];
  end

endmodule

@@ hdl/dll_free_stack.sv @@
module dll_free_stack (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pop,
  input  logic                      push,
  input  logic [dll_pkg::IdxW-1:0]  push_idx,
  output logic [dll_pkg::IdxW-1:0]  top_idx,
  output logic                      empty
);
  import dll_pkg::*;

  // Entries never written since reset read as their own index, which is
  // what the stack holds after reset until first overwritten. The top entry
  // is read through a register, so after a push or a pop top_idx is valid
  // once top_r and then the read register top_rd_r have been updated.
  logic [IdxW-1:0]  stk [Capacity];
  logic [Capacity-1:0] wrt_r;
  logic [LinkW-1:0] top_r;
  logic [IdxW-1:0]  ta;
  logic [IdxW-1:0]  top_rd_r;
  logic             top_wrt_r;

  assign ta = IdxW'(top_r - LinkW'(1));
  assign top_idx = top_wrt_r ? top_rd_r : ta;
  assign empty = (top_r == '0);

  always_ff @(posedge clk) begin
    if (push) stk[top_r[IdxW-1:0]] <= push_idx;
    top_rd_r <= stk[ta];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= LinkW'(Capacity);
      wrt_r <= '0;
      top_wrt_r <= 1'b0;
    end else begin
      top_wrt_r <= wrt_r[ta];
      if (pop) begin
        top_r <= top_r - LinkW'(1);
      end else if (push) begin
        top_r <= top_r + LinkW'(1);
        wrt_r[top_r[IdxW-1:0]] <= 1'b1;
      end
    end
  end

endmodule

@@ hdl/doubly_linked_list_engine.sv @@
// List engine: keeps up to 64 signed values in a linked node store held in
// synchronous RAMs with a registered read. A push passes through fetch and
// link steps before its result; a pop through fetch, wait, look and two
// unlink steps. Insert-after, delete and read-out walk the list node by node
// (one RAM read and its compare per node); read-out gives one result per
// element and waits while the receiver stalls.
// Sort is a bubble sort that walks the list with one read per node and a
// value swap for each out-of-order pair. A new item is taken only once the
// previous item's last result has been accepted and the engine is idle again.
module doubly_linked_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic signed [31:0] in_item_value,
  input  logic signed [31:0] in_after_key,
  input  logic        in_reverse_order,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_out_value,
  output logic [6:0]  out_element_total,
  output logic        out_last_result
);
  import dll_pkg::*;

  state_t st_r, st_nxt;
  op_t op_r, op_nxt;
  logic [31:0] val_r, val_nxt, key_r, key_nxt;
  logic rev_r, rev_nxt;
  logic [LinkW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [LinkW-1:0] cur_r, cur_nxt, at_r, at_nxt;
  logic [LinkW-1:0] cnt_r, cnt_nxt;
  logic [LinkW-1:0] k_r, k_nxt, pass_r, pass_nxt;
  logic swp_r, swp_nxt;
  logic [31:0] a_val_r, a_val_nxt;
  logic [LinkW-1:0] succ_r, succ_nxt, pred_r, pred_nxt;

  node_wr_t wr_r, wr_nxt;
  node_rd_t rd;
  logic [IdxW-1:0] rd_addr;
  logic fs_pop_r, fs_pop_nxt, fs_push_r, fs_push_nxt, fs_empty;
  logic [IdxW-1:0] fs_top;

  status_t     o_st_r, o_st_nxt;
  logic [31:0] o_val_r, o_val_nxt;
  logic        o_last_r, o_last_nxt, o_vld_r, o_vld_nxt;

  logic [1:0] ph_r, ph_nxt;

  logic key_hit, sort_gt, emit_go, emit_end, sort_more, sort_again;
  logic [LinkW-1:0] walk_link;

  dll_node_mem u_mem (.clk(clk), .wr(wr_r), .rd_addr(rd_addr), .rd(rd));
  dll_free_stack u_fs (.clk(clk), .rst_n(rst_n), .pop(fs_pop_r), .push(fs_push_r),
    .push_idx(at_r[IdxW-1:0]), .top_idx(fs_top), .empty(fs_empty));

  assign in_ready = (st_r == S_IDLE) && !o_vld_r;
  assign out_valid = o_vld_r;
  assign out_status = o_st_r;
  assign out_out_value = o_val_r;
  assign out_element_total = 7'(cnt_r);
  assign out_last_result = o_last_r;
  assign rd_addr = cur_r[IdxW-1:0];

  assign key_hit = (rd.val == key_r);
  assign sort_gt = $signed(a_val_r) > $signed(rd.val);
  assign emit_go = !o_vld_r || out_ready;
  assign walk_link = rev_r ? rd.prv : rd.nxt;
  assign emit_end = (k_r + LinkW'(1) >= cnt_r) || (walk_link == Nil);
  assign sort_more = (k_r + LinkW'(2)) < (cnt_r - pass_r);
  assign sort_again = (swp_r || sort_gt) && ((pass_r + LinkW'(2)) < cnt_r);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_valid && in_ready) st_nxt = S_FETCH;
      S_FETCH: begin
        case (op_r)
          OP_PUSH_FRONT, OP_PUSH_BACK: st_nxt = fs_empty ? S_DONE : S_LINK;
          OP_INSERT_AFT: st_nxt = (fs_empty || head_r == Nil) ? S_DONE : S_WAIT;
          OP_DELETE: st_nxt = (head_r == Nil) ? S_DONE : S_WAIT;
          OP_POP_FRONT, OP_POP_BACK: st_nxt = (cnt_r == '0) ? S_DONE : S_WAIT;
          OP_SORT: st_nxt = (cnt_r < LinkW'(2)) ? S_DONE : S_SORT_A;
          OP_READ: st_nxt = (cnt_r == '0) ? S_DONE : S_EMIT;
          default: st_nxt = S_DONE;
        endcase
      end
      S_WAIT: st_nxt = S_LOOK;
      S_LOOK: begin
        case (op_r)
          OP_POP_FRONT, OP_POP_BACK: st_nxt = S_UNLINK;
          OP_DELETE, OP_INSERT_AFT: begin
            if (key_hit) st_nxt = (op_r == OP_DELETE) ? S_UNLINK : S_LINK;
            else if (rd.nxt == Nil) st_nxt = S_DONE;
            else st_nxt = S_WAIT;
          end
          default: st_nxt = S_DONE;
        endcase
      end
      S_LINK: begin
        if (op_r == OP_INSERT_AFT && succ_r != Nil) st_nxt = S_UNLINK;
        else st_nxt = S_DONE;
      end
      S_UNLINK: if (ph_r != 2'd0) st_nxt = S_DONE;
      S_SORT_A: if (ph_r == 2'd1) st_nxt = S_SORT_B;
      S_SORT_B: if (ph_r == 2'd1) st_nxt = S_SORT_C;
      S_SORT_C: begin
        if (sort_more) st_nxt = S_SORT_B;
        else if (sort_again) st_nxt = S_SORT_A;
        else st_nxt = S_DONE;
      end
      S_EMIT: if (emit_go && ph_r == 2'd1 && emit_end) st_nxt = S_DONE;
      S_DONE: if (!o_vld_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt = op_r; val_nxt = val_r; key_nxt = key_r; rev_nxt = rev_r;
    head_nxt = head_r; tail_nxt = tail_r; cur_nxt = cur_r; at_nxt = at_r;
    cnt_nxt = cnt_r; k_nxt = k_r; pass_nxt = pass_r; swp_nxt = swp_r;
    a_val_nxt = a_val_r; succ_nxt = succ_r; pred_nxt = pred_r;
    o_st_nxt = o_st_r; o_val_nxt = o_val_r; o_last_nxt = o_last_r;
    o_vld_nxt = o_vld_r && !out_ready;
    ph_nxt = ph_r;
    wr_nxt = '0;
    fs_pop_nxt = 1'b0;
    fs_push_nxt = 1'b0;
    case (st_r)
      S_IDLE: if (in_valid && in_ready) begin
        op_nxt = op_t'(in_opcode); val_nxt = in_item_value;
        key_nxt = (in_opcode == OP_INSERT_AFT) ? in_after_key : in_item_value;
        rev_nxt = in_reverse_order;
        k_nxt = '0; pass_nxt = '0; swp_nxt = 1'b0;
      end
      S_FETCH: begin
        o_val_nxt = '0; o_last_nxt = 1'b1; o_st_nxt = ST_OK;
        case (op_r)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (fs_empty) begin
              o_st_nxt = ST_FULL; o_vld_nxt = 1'b1;
            end else begin
              at_nxt = {1'b0, fs_top}; fs_pop_nxt = 1'b1;
              wr_nxt.val_we = 1'b1; wr_nxt.nxt_we = 1'b1; wr_nxt.prv_we = 1'b1;
              wr_nxt.addr = fs_top; wr_nxt.val = val_r;
              wr_nxt.nxt = (op_r == OP_PUSH_FRONT) ? head_r : Nil;
              wr_nxt.prv = (op_r == OP_PUSH_FRONT) ? Nil : tail_r;
            end
          end
          OP_INSERT_AFT: begin
            if (fs_empty) begin
              o_st_nxt = ST_FULL; o_vld_nxt = 1'b1;
            end else if (head_r == Nil) begin
              o_st_nxt = ST_NOKEY; o_vld_nxt = 1'b1;
            end else cur_nxt = head_r;
          end
          OP_DELETE: begin
            if (head_r == Nil) begin
              o_st_nxt = ST_NOKEY; o_vld_nxt = 1'b1;
            end else cur_nxt = head_r;
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            if (cnt_r == '0) begin
              o_st_nxt = ST_EMPTY; o_vld_nxt = 1'b1;
            end else cur_nxt = (op_r == OP_POP_FRONT) ? head_r : tail_r;
          end
          OP_SORT: begin
            if (cnt_r < LinkW'(2)) begin
              o_vld_nxt = 1'b1;
            end else begin
              cur_nxt = head_r; ph_nxt = '0;
            end
          end
          OP_READ: begin
            if (cnt_r == '0) begin
              o_st_nxt = ST_EMPTY; o_vld_nxt = 1'b1;
            end else begin
              cur_nxt = rev_r ? tail_r : head_r; ph_nxt = '0;
            end
          end
          default: ;
        endcase
      end
      S_LOOK: begin
        // rd holds the node at cur_r.
        case (op_r)
          OP_POP_FRONT, OP_POP_BACK: begin
            o_val_nxt = rd.val; at_nxt = cur_r; succ_nxt = rd.nxt; pred_nxt = rd.prv;
            ph_nxt = '0;
          end
          OP_DELETE, OP_INSERT_AFT: begin
            if (key_hit) begin
              at_nxt = cur_r; succ_nxt = rd.nxt; pred_nxt = rd.prv;
              if (op_r == OP_DELETE) begin
                ph_nxt = '0;
              end else begin
                fs_pop_nxt = 1'b1;
                wr_nxt.val_we = 1'b1; wr_nxt.nxt_we = 1'b1; wr_nxt.prv_we = 1'b1;
                wr_nxt.addr = fs_top; wr_nxt.val = val_r;
                wr_nxt.nxt = rd.nxt; wr_nxt.prv = cur_r;
                cur_nxt = {1'b0, fs_top};
              end
            end else if (rd.nxt == Nil) begin
              o_st_nxt = ST_NOKEY; o_vld_nxt = 1'b1;
            end else begin
              cur_nxt = rd.nxt;
            end
          end
          default: ;
        endcase
      end
      S_LINK: begin
        // Patch the neighbors of the new node.
        cnt_nxt = cnt_r + LinkW'(1);
        case (op_r)
          OP_PUSH_FRONT: begin
            if (head_r == Nil) tail_nxt = at_r;
            else begin
              wr_nxt.prv_we = 1'b1; wr_nxt.addr = head_r[IdxW-1:0]; wr_nxt.prv = at_r;
            end
            head_nxt = at_r;
            o_vld_nxt = 1'b1;
          end
          OP_PUSH_BACK: begin
            if (tail_r == Nil) head_nxt = at_r;
            else begin
              wr_nxt.nxt_we = 1'b1; wr_nxt.addr = tail_r[IdxW-1:0]; wr_nxt.nxt = at_r;
            end
            tail_nxt = at_r;
            o_vld_nxt = 1'b1;
          end
          default: begin
            // at_r: key node, cur_r: new node; a second write follows if at_r had a successor.
            wr_nxt.nxt_we = 1'b1; wr_nxt.addr = at_r[IdxW-1:0]; wr_nxt.nxt = cur_r;
            if (succ_r == Nil) begin
              tail_nxt = cur_r; o_vld_nxt = 1'b1;
            end else ph_nxt = 2'd3;
          end
        endcase
      end
      S_UNLINK: begin
        ph_nxt = ph_r + 2'd1;
        case (ph_r)
          2'd0: begin
            if (pred_r == Nil) head_nxt = succ_r;
            else begin
              wr_nxt.nxt_we = 1'b1; wr_nxt.addr = pred_r[IdxW-1:0]; wr_nxt.nxt = succ_r;
            end
          end
          2'd1: begin
            if (succ_r == Nil) tail_nxt = pred_r;
            else begin
              wr_nxt.prv_we = 1'b1; wr_nxt.addr = succ_r[IdxW-1:0]; wr_nxt.prv = pred_r;
            end
            fs_push_nxt = 1'b1;
            cnt_nxt = cnt_r - LinkW'(1);
            o_vld_nxt = 1'b1;
          end
          2'd3: begin
            // Insert-after tail of the work: back link of the old successor.
            wr_nxt.prv_we = 1'b1; wr_nxt.addr = succ_r[IdxW-1:0]; wr_nxt.prv = cur_r;
            o_vld_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      S_SORT_A: begin
        // Read node cur_r; its successor follows.
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd1) begin
          a_val_nxt = rd.val; at_nxt = cur_r;
          cur_nxt = rd.nxt; ph_nxt = '0;
        end
      end
      S_SORT_B: begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd1) begin
          if (sort_gt) begin
            wr_nxt.val_we = 1'b1; wr_nxt.addr = at_r[IdxW-1:0]; wr_nxt.val = rd.val;
            swp_nxt = 1'b1;
          end
          ph_nxt = '0;
        end
      end
      S_SORT_C: begin
        if (sort_gt) begin
          wr_nxt.val_we = 1'b1; wr_nxt.addr = cur_r[IdxW-1:0]; wr_nxt.val = a_val_r;
        end
        if (sort_more) begin
          k_nxt = k_r + LinkW'(1);
          a_val_nxt = sort_gt ? a_val_r : rd.val; at_nxt = cur_r;
          cur_nxt = rd.nxt; ph_nxt = '0;
        end else if (sort_again) begin
          pass_nxt = pass_r + LinkW'(1); k_nxt = '0; swp_nxt = 1'b0;
          cur_nxt = head_r; ph_nxt = '0;
        end else begin
          o_vld_nxt = 1'b1;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          ph_nxt = ph_r + 2'd1;
          if (ph_r == 2'd1) begin
            o_val_nxt = rd.val; o_st_nxt = ST_OK;
            o_last_nxt = emit_end;
            o_vld_nxt = 1'b1;
            k_nxt = k_r + LinkW'(1);
            cur_nxt = walk_link; ph_nxt = '0;
          end
        end else ph_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      head_r <= Nil; tail_r <= Nil; cnt_r <= '0;
      o_vld_r <= 1'b0;
      wr_r <= '0; fs_pop_r <= 1'b0; fs_push_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; cnt_r <= cnt_nxt;
      o_vld_r <= o_vld_nxt;
      wr_r <= wr_nxt; fs_pop_r <= fs_pop_nxt; fs_push_r <= fs_push_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; val_r <= val_nxt; key_r <= key_nxt; rev_r <= rev_nxt;
    cur_r <= cur_nxt; at_r <= at_nxt;
    k_r <= k_nxt; pass_r <= pass_nxt; swp_r <= swp_nxt;
    a_val_r <= a_val_nxt; succ_r <= succ_nxt; pred_r <= pred_nxt;
    o_st_r <= o_st_nxt; o_val_r <= o_val_nxt; o_last_r <= o_last_nxt;
    ph_r <= ph_nxt;
  end

endmodule
